[design/tvws_pkg.sv]
// Shared constants, types and the sine ROM contents for the two-voice synth.
package tvws_pkg;

  // Table geometry (TABLE_SIZE must be a power of two, 16 to 4096)
  localparam int TABLE_SIZE = 1024;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int FRAC_W     = 16;
  localparam int PHASE_W    = IDX_W + FRAC_W;

  // Field widths
  localparam int STEP_W     = 26;
  localparam int STEP_SEL_W = $clog2(STEP_W);
  localparam int VOL_W      = 16;
  localparam int PWM_W      = 16;
  localparam int LEVEL_W    = 16;
  localparam int SINE_W     = 15;
  localparam int CFG_IDX_W  = 2;

  // Sequencer counter covers the longest pass (the phase shift)
  localparam int CNT_W      = $clog2(PHASE_W);

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_A  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_B  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PWM_TOP = 2'd2;

  localparam logic [PWM_W-1:0] PWM_TOP_RST = 16'hFFFF;

  // Control for the bit-serial phase accumulators
  typedef struct packed {
    logic             shift;
    logic [CNT_W-1:0] bit_idx;
    logic             load_a;
    logic             load_b;
  } phase_ctl_t;

  // Control for the shift-add multiplier
  typedef struct packed {
    logic load;
    logic step;
  } mul_ctl_t;

  // Q30 constants for building the ROM
  localparam longint Q30_ONE     = 64'sd1073741824;
  localparam longint Q30_PI      = 64'sd3373259426;
  localparam longint Q30_HALF_PI = 64'sd1686629713;
  localparam longint ROM_DEN     = 100 * TABLE_SIZE;

  typedef logic [SINE_W-1:0] rom_t [TABLE_SIZE];

  // term * x * x in Q30, each product truncated toward zero
  function automatic longint sq_q30(longint term, longint x);
    longint t;
    t = (term * x) / Q30_ONE;
    return (t * x) / Q30_ONE;
  endfunction

  // Sine of a Q30 angle in [0, 2*pi) by folded Taylor series
  function automatic longint sin_q30(longint xin);
    longint x;
    longint sum;
    longint term;
    logic   neg;
    x   = xin;
    neg = 1'b0;
    if (x >= Q30_PI) begin
      x   = x - Q30_PI;
      neg = 1'b1;
    end
    if (x > Q30_HALF_PI) begin
      x = Q30_PI - x;
    end
    sum  = x;
    term = x;
    term = -sq_q30(term, x) / 6;   sum = sum + term;
    term = -sq_q30(term, x) / 20;  sum = sum + term;
    term = -sq_q30(term, x) / 42;  sum = sum + term;
    term = -sq_q30(term, x) / 72;  sum = sum + term;
    term = -sq_q30(term, x) / 110; sum = sum + term;
    term = -sq_q30(term, x) / 156; sum = sum + term;
    term = -sq_q30(term, x) / 210; sum = sum + term;
    term = -sq_q30(term, x) / 272; sum = sum + term;
    term = -sq_q30(term, x) / 342; sum = sum + term;
    term = -sq_q30(term, x) / 420; sum = sum + term;
    term = -sq_q30(term, x) / 506; sum = sum + term;
    term = -sq_q30(term, x) / 600; sum = sum + term;
    return neg ? -sum : sum;
  endfunction

  // Offset sine table, evaluated at elaboration
  function automatic rom_t build_rom();
    rom_t   rom;
    longint num;
    longint x;
    longint p;
    longint v;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      num = 64'sd628 * longint'(i) * Q30_ONE;
      x   = num / ROM_DEN;
      p   = 64'sd16383 * sin_q30(x) + 64'sd16384 * Q30_ONE;
      v   = (p < 0) ? 64'sd0 : (p >>> 30);
      rom[i] = SINE_W'(v);
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

endpackage

[design/tvws_phase_acc.sv]
// Bit-serial phase accumulators and tuning words for both voices.
module tvws_phase_acc (
  input  logic                             clk,
  input  logic                             rst_n,
  input  tvws_pkg::phase_ctl_t             ctl,
  input  logic [tvws_pkg::STEP_W-1:0]      cfg_data,
  output logic [tvws_pkg::IDX_W-1:0]       idx_a,
  output logic [tvws_pkg::IDX_W-1:0]       idx_b
);

  logic [tvws_pkg::STEP_W-1:0]  step_a_r, step_a_nxt;
  logic [tvws_pkg::STEP_W-1:0]  step_b_r, step_b_nxt;
  logic [tvws_pkg::PHASE_W-1:0] phase_a_r, phase_a_nxt;
  logic [tvws_pkg::PHASE_W-1:0] phase_b_r, phase_b_nxt;
  logic                         carry_a_r, carry_a_nxt;
  logic                         carry_b_r, carry_b_nxt;
  logic                         in_range;
  logic                         sbit_a, sbit_b;
  logic [1:0]                   sum_a, sum_b;

  // Pick the tuning-word bit for this cycle; bits above the word are zero
  assign in_range = ctl.bit_idx < tvws_pkg::CNT_W'(tvws_pkg::STEP_W);
  assign sbit_a = in_range ? step_a_r[tvws_pkg::STEP_SEL_W'(ctl.bit_idx)] : 1'b0;
  assign sbit_b = in_range ? step_b_r[tvws_pkg::STEP_SEL_W'(ctl.bit_idx)] : 1'b0;

  // One full-adder per voice, LSB first
  assign sum_a = 2'(phase_a_r[0]) + 2'(sbit_a) + 2'(carry_a_r);
  assign sum_b = 2'(phase_b_r[0]) + 2'(sbit_b) + 2'(carry_b_r);

  always_comb begin
    step_a_nxt  = step_a_r;
    step_b_nxt  = step_b_r;
    phase_a_nxt = phase_a_r;
    phase_b_nxt = phase_b_r;
    carry_a_nxt = 1'b0;
    carry_b_nxt = 1'b0;
    // Shift the sum bit in at the top; carry out of the top bit drops (wrap)
    if (ctl.shift) begin
      phase_a_nxt = {sum_a[0], phase_a_r[tvws_pkg::PHASE_W-1:1]};
      phase_b_nxt = {sum_b[0], phase_b_r[tvws_pkg::PHASE_W-1:1]};
      carry_a_nxt = sum_a[1];
      carry_b_nxt = sum_b[1];
    end
    // Register writes; a zero tuning word parks the phase at zero
    if (ctl.load_a) begin
      step_a_nxt = cfg_data;
      if (cfg_data == '0) begin
        phase_a_nxt = '0;
      end
    end
    if (ctl.load_b) begin
      step_b_nxt = cfg_data;
      if (cfg_data == '0) begin
        phase_b_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_a_r  <= '0;
      step_b_r  <= '0;
      phase_a_r <= '0;
      phase_b_r <= '0;
      carry_a_r <= 1'b0;
      carry_b_r <= 1'b0;
    end else begin
      step_a_r  <= step_a_nxt;
      step_b_r  <= step_b_nxt;
      phase_a_r <= phase_a_nxt;
      phase_b_r <= phase_b_nxt;
      carry_a_r <= carry_a_nxt;
      carry_b_r <= carry_b_nxt;
    end
  end

  assign idx_a = phase_a_r[tvws_pkg::PHASE_W-1:tvws_pkg::FRAC_W];
  assign idx_b = phase_b_r[tvws_pkg::PHASE_W-1:tvws_pkg::FRAC_W];

endmodule

[design/tvws_serial_mul.sv]
// Shift-add multiplier, one multiplier bit per cycle while step is set, keeps product >> 16.
module tvws_serial_mul (
  input  logic                         clk,
  input  tvws_pkg::mul_ctl_t           ctl,
  input  logic [tvws_pkg::SINE_W-1:0]  mcand,
  input  logic [tvws_pkg::VOL_W-1:0]   mplier,
  output logic [tvws_pkg::SINE_W-1:0]  result
);

  logic [tvws_pkg::SINE_W-1:0] mcand_r, mcand_nxt;
  logic [tvws_pkg::VOL_W-1:0]  mplier_r, mplier_nxt;
  logic [tvws_pkg::SINE_W-1:0] acc_r, acc_nxt;
  logic [tvws_pkg::SINE_W:0]   psum;

  // Add the multiplicand when the current multiplier bit is set
  assign psum = {1'b0, acc_r} + (mplier_r[0] ? {1'b0, mcand_r} : '0);

  always_comb begin
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    acc_nxt    = acc_r;
    if (ctl.load) begin
      mcand_nxt  = mcand;
      mplier_nxt = mplier;
      acc_nxt    = '0;
    end else if (ctl.step) begin
      // Drop the low bit each step: after all bits acc holds the upper half
      mplier_nxt = {1'b0, mplier_r[tvws_pkg::VOL_W-1:1]};
      acc_nxt    = psum[tvws_pkg::SINE_W:1];
    end
  end

  always_ff @(posedge clk) begin
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    acc_r    <= acc_nxt;
  end

  assign result = acc_r;

endmodule

[design/two_voice_wavetable_synth.sv]
// Top level of the two-voice sine synthesiser with PWM level scaling.
// Usage:
//   Input channel (in_valid / in_stall / in_volume): one transfer per audio
//   sample tick. Each transfer advances both voice phases, looks up the sine
//   ROM for each voice, averages the two, scales by volume and by pwm_top.
//   Result channel (out_valid / out_stall / out_pwm_level): one transfer per
//   input transfer, in order.
//   Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0 is
//   the voice A tuning word, 1 the voice B tuning word, 2 pwm_top. Other
//   indexes are ignored. A zero tuning word also clears that voice's phase.
// Sequence:
//   Each item runs through bit-serial phase addition, ROM reads (voice A,
//   then voice B), two 16-bit shift-add multiplies on a shared unit (volume,
//   then pwm_top), a load of the result into the output register, then an
//   idle state in which the result is already shown. No new input transfer
//   is accepted until the item has finished.
// Reset: synchronous, active low; phases and tuning words go to zero, pwm_top
//   to 65535, no result pending.
// Stall: a stalled result holds in the output register while the next item
//   is accepted; a finished item waits until the output register is free.
module two_voice_wavetable_synth (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [tvws_pkg::VOL_W-1:0]        in_volume,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [tvws_pkg::LEVEL_W-1:0]      out_pwm_level,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tvws_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tvws_pkg::STEP_W-1:0]       cfg_data
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PHASE = 6'b000010,
    ST_ROM   = 6'b000100,
    ST_MUL1  = 6'b001000,
    ST_MUL2  = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  localparam logic [tvws_pkg::CNT_W-1:0] PHASE_LAST = tvws_pkg::CNT_W'(tvws_pkg::PHASE_W - 1);
  localparam logic [tvws_pkg::CNT_W-1:0] MUL1_LAST  = tvws_pkg::CNT_W'(tvws_pkg::VOL_W - 1);
  localparam logic [tvws_pkg::CNT_W-1:0] MUL2_LAST  = tvws_pkg::CNT_W'(tvws_pkg::PWM_W);

  state_t                          state_r, state_nxt;
  logic [tvws_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [tvws_pkg::VOL_W-1:0]      vol_r, vol_nxt;
  logic [tvws_pkg::PWM_W-1:0]      pwm_top_r, pwm_top_nxt;
  logic [tvws_pkg::SINE_W-1:0]     rom_q_r;
  logic [tvws_pkg::SINE_W-1:0]     a_val_r, a_val_nxt;
  logic [tvws_pkg::LEVEL_W-1:0]    level_r, level_nxt;
  logic                            out_valid_r, out_valid_nxt;

  tvws_pkg::phase_ctl_t            phase_ctl;
  tvws_pkg::mul_ctl_t              mul_ctl;
  logic [tvws_pkg::IDX_W-1:0]      idx_a, idx_b;
  logic [tvws_pkg::IDX_W-1:0]      rom_addr;
  logic [tvws_pkg::SINE_W:0]       pair_sum;
  logic [tvws_pkg::SINE_W-1:0]     mul_a;
  logic [tvws_pkg::VOL_W-1:0]      mul_b;
  logic [tvws_pkg::SINE_W-1:0]     mul_res;
  logic                            cfg_wr;
  logic                            out_free;

  assign cfg_ready = (state_r == ST_IDLE);
  assign cfg_wr    = cfg_valid & cfg_ready;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;

  // Sum of the two table entries; its upper bits are their average
  assign pair_sum = {1'b0, a_val_r} + {1'b0, rom_q_r};

  // Phase accumulators
  tvws_phase_acc u_phase (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (phase_ctl),
    .cfg_data (cfg_data),
    .idx_a    (idx_a),
    .idx_b    (idx_b)
  );

  // Shared scaling multiplier
  tvws_serial_mul u_mul (
    .clk    (clk),
    .ctl    (mul_ctl),
    .mcand  (mul_a),
    .mplier (mul_b),
    .result (mul_res)
  );

  // Sine ROM, registered read
  always_ff @(posedge clk) begin
    rom_q_r <= tvws_pkg::SINE_ROM[rom_addr];
  end

  // Sequencer
  always_comb begin
    state_nxt         = state_r;
    cnt_nxt           = cnt_r;
    vol_nxt           = vol_r;
    pwm_top_nxt       = pwm_top_r;
    a_val_nxt         = a_val_r;
    level_nxt         = level_r;
    out_valid_nxt     = out_valid_r;
    rom_addr          = (cnt_r == '0) ? idx_a : idx_b;
    phase_ctl.shift   = 1'b0;
    phase_ctl.bit_idx = cnt_r;
    phase_ctl.load_a  = cfg_wr && (cfg_index == tvws_pkg::CFG_STEP_A);
    phase_ctl.load_b  = cfg_wr && (cfg_index == tvws_pkg::CFG_STEP_B);
    mul_ctl.load      = 1'b0;
    mul_ctl.step      = 1'b0;
    mul_a             = pair_sum[tvws_pkg::SINE_W:1];
    mul_b             = vol_r;

    // Drop the result once the receiver takes it
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_wr && (cfg_index == tvws_pkg::CFG_PWM_TOP)) begin
      pwm_top_nxt = cfg_data[tvws_pkg::PWM_W-1:0];
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          vol_nxt   = in_volume;
          cnt_nxt   = '0;
          state_nxt = ST_PHASE;
        end
      end
      ST_PHASE: begin
        phase_ctl.shift = 1'b1;
        if (cnt_r == PHASE_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_ROM;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_ROM: begin
        // Read A, then B; hold A and start the volume multiply on the average of A and B
        if (cnt_r == tvws_pkg::CNT_W'(1)) begin
          a_val_nxt = rom_q_r;
        end
        if (cnt_r == tvws_pkg::CNT_W'(2)) begin
          mul_ctl.load = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = ST_MUL1;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_MUL1: begin
        mul_ctl.step = 1'b1;
        if (cnt_r == MUL1_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_MUL2;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_MUL2: begin
        // Reload with the volume product and pwm_top, then shift through
        mul_a = mul_res;
        mul_b = pwm_top_r;
        if (cnt_r == '0) begin
          mul_ctl.load = 1'b1;
        end else begin
          mul_ctl.step = 1'b1;
        end
        if (cnt_r == MUL2_LAST) begin
          state_nxt = ST_OUT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_OUT: begin
        // Hold until the output register is free
        if (out_free) begin
          level_nxt     = tvws_pkg::LEVEL_W'(mul_res);
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      pwm_top_r   <= tvws_pkg::PWM_TOP_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pwm_top_r   <= pwm_top_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    vol_r   <= vol_nxt;
    a_val_r <= a_val_nxt;
    level_r <= level_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_pwm_level = level_r;

endmodule

[design/tvws_checker.sv]
// Port-level checks for the two-voice synth, bound to the top level.
module tvws_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [tvws_pkg::LEVEL_W-1:0]   out_pwm_level,
  input logic                           cfg_ready
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pwm_level))
    else $error("stalled result changed or dropped");

  // Leave reset idle with nothing pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall && cfg_ready)
    else $error("block not idle after reset");

  // Go busy after every input transfer
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall && !cfg_ready)
    else $error("input transfer did not start work");

  // Raise a new result only at the end of a busy period
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall) && !in_stall)
    else $error("result appeared without work");

endmodule

bind two_voice_wavetable_synth tvws_checker u_tvws_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_pwm_level (out_pwm_level),
  .cfg_ready     (cfg_ready)
);

[tb/two_voice_wavetable_synth_tb.sv]
// Self-checking testbench for the two-voice sine synthesiser: predicts each PWM level.

// Tracks tuning, phases and the sine table; holds the PWM levels still owed by the block
class synth_scoreboard;
  localparam longint FIX_ONE     = 64'sd1073741824;
  localparam longint FIX_PI      = 64'sd3373259426;
  localparam longint FIX_HALF_PI = 64'sd1686629713;

  logic [tvws_pkg::SINE_W-1:0]  sine_lut [tvws_pkg::TABLE_SIZE];
  logic [tvws_pkg::PHASE_W-1:0] phase_a;
  logic [tvws_pkg::PHASE_W-1:0] phase_b;
  logic [tvws_pkg::STEP_W-1:0]  step_a;
  logic [tvws_pkg::STEP_W-1:0]  step_b;
  logic [tvws_pkg::PWM_W-1:0]   pwm_top;
  logic [tvws_pkg::LEVEL_W-1:0] level_q [$];
  int errors;
  int checked;

  // Sine of an angle in Q30, folded into the first quadrant, truncating series
  function longint sine_q30(longint ang);
    longint x;
    longint acc;
    longint term;
    bit     neg;
    x   = ang;
    neg = 1'b0;
    if (x >= FIX_PI) begin
      x   = x - FIX_PI;
      neg = 1'b1;
    end
    if (x > FIX_HALF_PI) begin
      x = FIX_PI - x;
    end
    acc  = x;
    term = x;
    for (int n = 1; n <= 12; n++) begin
      term = (term * x) / FIX_ONE;
      term = (term * x) / FIX_ONE;
      term = -term / longint'((2 * n) * (2 * n + 1));
      acc  = acc + term;
    end
    return neg ? -acc : acc;
  endfunction

  function new();
    longint num;
    longint p;
    // Fill the offset sine table; the angle uses 3.14 for pi as the ROM does
    for (int i = 0; i < tvws_pkg::TABLE_SIZE; i++) begin
      num = 64'sd628 * longint'(i) * FIX_ONE;
      p   = 64'sd16383 * sine_q30(num / longint'(100 * tvws_pkg::TABLE_SIZE))
            + 64'sd16384 * FIX_ONE;
      sine_lut[i] = (p < 0) ? '0 : tvws_pkg::SINE_W'(p >>> 30);
    end
    phase_a = '0;
    phase_b = '0;
    step_a  = '0;
    step_b  = '0;
    pwm_top = tvws_pkg::PWM_TOP_RST;
    errors  = 0;
    checked = 0;
  endfunction

  // Apply a register transfer; a zero tuning word also clears that voice
  function void write_reg(logic [tvws_pkg::CFG_IDX_W-1:0] idx,
                          logic [tvws_pkg::STEP_W-1:0] data);
    case (idx)
      tvws_pkg::CFG_STEP_A: begin
        step_a = data;
        if (data == '0) phase_a = '0;
      end
      tvws_pkg::CFG_STEP_B: begin
        step_b = data;
        if (data == '0) phase_b = '0;
      end
      tvws_pkg::CFG_PWM_TOP: begin
        pwm_top = data[tvws_pkg::PWM_W-1:0];
      end
      default: begin
      end
    endcase
  endfunction

  function logic [tvws_pkg::PHASE_W-1:0] advance(logic [tvws_pkg::PHASE_W-1:0] ph,
                                                  logic [tvws_pkg::STEP_W-1:0] st);
    longint wrap;
    wrap = longint'(tvws_pkg::TABLE_SIZE) << tvws_pkg::FRAC_W;
    if (st == '0) return '0;
    return tvws_pkg::PHASE_W'((longint'(ph) + longint'(st)) % wrap);
  endfunction

  // One sample tick: step both voices, mix, scale by volume then pwm_top
  function void accept_tick(logic [tvws_pkg::VOL_W-1:0] vol);
    int     ia;
    int     ib;
    longint mix;
    phase_a = advance(phase_a, step_a);
    phase_b = advance(phase_b, step_b);
    ia  = int'(phase_a >> tvws_pkg::FRAC_W) % tvws_pkg::TABLE_SIZE;
    ib  = int'(phase_b >> tvws_pkg::FRAC_W) % tvws_pkg::TABLE_SIZE;
    mix = (longint'(sine_lut[ia]) + longint'(sine_lut[ib])) >> 1;
    mix = (mix * longint'(vol)) >> 16;
    mix = (mix * longint'(pwm_top)) >> 16;
    level_q.push_back(tvws_pkg::LEVEL_W'(mix));
  endfunction

  function void check_level(logic [tvws_pkg::LEVEL_W-1:0] level);
    logic [tvws_pkg::LEVEL_W-1:0] want;
    if (level_q.size() == 0) begin
      $display("%0t: unexpected PWM level transfer: expected none, got %0d", $time, level);
      errors++;
      return;
    end
    want = level_q.pop_front();
    checked++;
    if (level !== want) begin
      $display("%0t: pwm_level mismatch: expected %0d, got %0d", $time, want, level);
      errors++;
    end
  endfunction

  function int pending();
    return level_q.size();
  endfunction
endclass

module two_voice_wavetable_synth_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_CYCLES = tvws_pkg::PHASE_W + 38;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int RANDOM_TICKS = 2000;
  localparam logic [tvws_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [tvws_pkg::STEP_W-1:0] STEP_MAX = '1;
  localparam logic [tvws_pkg::STEP_W-1:0] STEP_ONE_ENTRY =
    tvws_pkg::STEP_W'(1) << tvws_pkg::FRAC_W;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_RUNS} stall_mode_t;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  logic [tvws_pkg::VOL_W-1:0]     in_volume;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [tvws_pkg::LEVEL_W-1:0]   out_pwm_level;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [tvws_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [tvws_pkg::STEP_W-1:0]    cfg_data;

  synth_scoreboard sb = new();
  int cycles = 0;
  int ticks_sent = 0;
  int settings = 0;

  two_voice_wavetable_synth DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_volume     (in_volume),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pwm_level (out_pwm_level),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // Give up on a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Check every PWM level transfer against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_level(out_pwm_level);
    end
  end

  // Receiver back-pressure: switch between no stall, coin flips and long runs
  stall_mode_t stall_mode = STALL_NONE;
  int  mode_left = 0;
  int  run_left = 0;
  logic stall_run = 1'b0;
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 2));
      mode_left  = $urandom_range(50, 600);
    end
    mode_left--;
    case (stall_mode)
      STALL_NONE: begin
        out_stall <= 1'b0;
      end
      STALL_RANDOM: begin
        out_stall <= 1'($urandom_range(0, 1));
      end
      default: begin
        if (run_left == 0) begin
          stall_run = !stall_run;
          run_left  = $urandom_range(1, 80);
        end
        run_left--;
        out_stall <= stall_run;
      end
    endcase
  end

  // Offer one volume and hold it until the block takes it
  task automatic send_tick(input logic [tvws_pkg::VOL_W-1:0] vol);
    in_valid  <= 1'b1;
    in_volume <= vol;
    do @(posedge clk); while (in_stall);
    sb.accept_tick(vol);
    ticks_sent++;
  endtask

  // Drop valid and wait until every predicted level has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
  endtask

  // Register transfer; valid stays up so writes can run back to back
  task automatic set_reg(input logic [tvws_pkg::CFG_IDX_W-1:0] idx,
                         input logic [tvws_pkg::STEP_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  task automatic cfg_release();
    cfg_valid <= 1'b0;
    settings++;
  endtask

  function automatic logic [tvws_pkg::STEP_W-1:0] pick_step();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return STEP_MAX;
      2: return tvws_pkg::STEP_W'($urandom_range(1, 1 << 20));
      3: return tvws_pkg::STEP_W'($urandom_range(1, tvws_pkg::TABLE_SIZE - 1))
                << tvws_pkg::FRAC_W;
      default: return tvws_pkg::STEP_W'($urandom);
    endcase
  endfunction

  function automatic logic [tvws_pkg::PWM_W-1:0] pick_top();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      default: return tvws_pkg::PWM_W'($urandom);
    endcase
  endfunction

  function automatic logic [tvws_pkg::VOL_W-1:0] pick_volume();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return tvws_pkg::VOL_W'($urandom);
    endcase
  endfunction

  // Random bursts of ticks separated by random gaps, some back to back
  task automatic run_bursts(input int count);
    int remaining;
    int burst;
    int gap;
    remaining = count;
    while (remaining > 0) begin
      burst = $urandom_range(1, 40);
      if (burst > remaining) burst = remaining;
      repeat (burst) send_tick(pick_volume());
      remaining -= burst;
      if (remaining > 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    drain();
  endtask

  initial begin
    int random_done;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_volume <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset tuning: both voices parked at entry zero
    send_tick('0);
    send_tick('1);
    send_tick(16'd1);
    send_tick(16'h8000);
    drain();

    // One entry per tick on A, full-scale word on B
    set_reg(tvws_pkg::CFG_STEP_A, STEP_ONE_ENTRY);
    set_reg(tvws_pkg::CFG_STEP_B, STEP_MAX);
    set_reg(tvws_pkg::CFG_PWM_TOP, tvws_pkg::STEP_W'(16'hFFFF));
    cfg_release();
    send_tick('1);
    send_tick(16'h5555);
    send_tick(16'hAAAA);
    send_tick('1);
    send_tick('1);
    drain();

    // Zero word clears B's phase; a write to the spare index must change nothing
    set_reg(tvws_pkg::CFG_STEP_B, '0);
    set_reg(CFG_SPARE, STEP_MAX);
    cfg_release();
    repeat (3) send_tick('1);
    drain();

    // pwm_top at zero silences the output
    set_reg(tvws_pkg::CFG_PWM_TOP, '0);
    cfg_release();
    send_tick('1);
    send_tick(16'd12345);
    drain();

    set_reg(tvws_pkg::CFG_PWM_TOP, tvws_pkg::STEP_W'(1));
    set_reg(tvws_pkg::CFG_STEP_A, STEP_MAX);
    set_reg(tvws_pkg::CFG_STEP_B, tvws_pkg::STEP_W'(1));
    cfg_release();
    send_tick('1);
    send_tick('1);
    drain();

    // A silent, B at half the table per tick
    set_reg(tvws_pkg::CFG_STEP_A, '0);
    set_reg(tvws_pkg::CFG_STEP_B,
            tvws_pkg::STEP_W'(tvws_pkg::TABLE_SIZE / 2) << tvws_pkg::FRAC_W);
    set_reg(tvws_pkg::CFG_PWM_TOP, tvws_pkg::STEP_W'(16'hFFFF));
    cfg_release();
    send_tick('1);
    send_tick('1);
    drain();

    // Random settings, each followed by a stretch of random ticks
    random_done = 0;
    while (random_done < RANDOM_TICKS) begin
      int count;
      if ($urandom_range(0, 3) == 0) set_reg(CFG_SPARE, tvws_pkg::STEP_W'($urandom));
      set_reg(tvws_pkg::CFG_STEP_A, pick_step());
      set_reg(tvws_pkg::CFG_STEP_B, pick_step());
      set_reg(tvws_pkg::CFG_PWM_TOP, tvws_pkg::STEP_W'(pick_top()));
      cfg_release();
      count = $urandom_range(50, 300);
      run_bursts(count);
      random_done += count;
    end

    // Let any stray result show up before judging
    repeat (2 * ITEM_CYCLES) @(posedge clk);

    $display("Checked %0d PWM levels from %0d sample ticks over %0d register settings.",
             sb.checked, ticks_sent, settings);
    $display("Tuning words ran from zero to full scale; volume and pwm_top hit both ends.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
